/* rtl/lla_pkg.sv */
// ----------------------------------------------------------------------------
// lla_pkg: shared definitions for the toroidal life-like automaton
// Grid geometry, derived widths, operation and response codes, the memory
// request bundle and small index helpers used by the core and its memory.
// ----------------------------------------------------------------------------
package lla_pkg;

  // Grid geometry. Each memory word holds one full row of cells.
  localparam int GRID_WIDTH  = 320;
  localparam int GRID_HEIGHT = 240;

  localparam int COL_IDX_W  = $clog2(GRID_WIDTH);
  localparam int ROW_IDX_W  = $clog2(GRID_HEIGHT);

  // Two banks of rows: the live grid and the generation being built.
  localparam int MEM_DEPTH  = 2 * GRID_HEIGHT;
  localparam int MEM_ADDR_W = $clog2(MEM_DEPTH);

  // Fixed field widths of the ports.
  localparam int OP_W       = 2;
  localparam int COLUMN_W   = 9;
  localparam int ROW_W      = 8;
  localparam int MASK_W     = 9;
  localparam int CFG_IDX_W  = 1;

  // Rule masks after reset: survive on 2 or 3, birth on 0 or 1.
  localparam logic [MASK_W-1:0] SURVIVE_RESET = MASK_W'(12);
  localparam logic [MASK_W-1:0] BIRTH_RESET   = MASK_W'(3);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_STEP   = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [OP_W-1:0] {
    RESP_WRITE = 2'd0,
    RESP_READ  = 2'd1,
    RESP_STEP  = 2'd2
  } resp_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SURVIVE = 1'b0,
    CFG_BIRTH   = 1'b1
  } cfg_idx_t;

  typedef logic [GRID_WIDTH-1:0] row_word_t;

  // One read and one write port per cycle on the row memory.
  typedef struct packed {
    logic                  rd_en;
    logic [MEM_ADDR_W-1:0] rd_addr;
    logic                  wr_en;
    logic [MEM_ADDR_W-1:0] wr_addr;
    row_word_t             wr_data;
  } mem_req_t;

  // Row index plus one, wrapping at the bottom edge of the torus.
  function automatic logic [ROW_IDX_W-1:0] row_inc(input logic [ROW_IDX_W-1:0] row);
    row_inc = (row == ROW_IDX_W'(GRID_HEIGHT - 1)) ? '0 : row + ROW_IDX_W'(1);
  endfunction

  // Memory address of a row within a bank.
  function automatic logic [MEM_ADDR_W-1:0] mem_addr(input logic bank,
                                                     input logic [ROW_IDX_W-1:0] row);
    mem_addr = bank ? (MEM_ADDR_W'(row) + MEM_ADDR_W'(GRID_HEIGHT)) : MEM_ADDR_W'(row);
  endfunction

endpackage

/* rtl/lla_grid_mem.sv */
// ----------------------------------------------------------------------------
// lla_grid_mem: row memory for both grid banks
// One row per word, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lla_grid_mem (
  input  logic                clk,
  input  lla_pkg::mem_req_t   req,
  output lla_pkg::row_word_t  rd_data
);
  import lla_pkg::*;

  row_word_t mem [MEM_DEPTH];
  row_word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/lla_rule_unit.sv */
// ----------------------------------------------------------------------------
// lla_rule_unit: neighbor count and birth/survive decision
// Counts the eight neighbor taps and looks the count up in the rule mask
// that matches the center cell.
// ----------------------------------------------------------------------------
module lla_rule_unit (
  input  logic [7:0]                 taps,
  input  logic                       center,
  input  logic [lla_pkg::MASK_W-1:0] survive_mask,
  input  logic [lla_pkg::MASK_W-1:0] birth_mask,
  output logic                       new_cell
);
  import lla_pkg::*;

  logic [3:0]        count;
  logic [MASK_W-1:0] rule;

  always_comb begin
    count = '0;
    for (int i = 0; i < 8; i++) begin
      count = count + 4'(taps[i]);
    end
    rule     = center ? survive_mask : birth_mask;
    new_cell = rule[count];
  end

endmodule

/* rtl/toroidal_life_like_automaton_step_core.sv */
// ----------------------------------------------------------------------------
// toroidal_life_like_automaton_step_core: life-like automaton on a torus
// Cell grid with cell write, cell read and one-generation step commands.
// ----------------------------------------------------------------------------
// The grid is held one row per memory word in two banks; a bank bit names
// the live one. After reset the core clears the live bank with one row write
// per cycle and holds in_stall high meanwhile; configuration writes are taken
// at any time. A cell write or read goes through a read of its row and, for
// a write, a write of the modified row, then through the result state that
// loads the output register. A cell outside the grid skips the memory and
// goes from the transfer straight to the result state. A step streams the
// grid through a three-row window that rotates one column per cycle past a
// single shared rule unit; after each row the new row is written to the
// other bank and the next row is loaded into the window, and the banks
// swap at the end of the step. The core works on one item at a time; its
// result waits in an output register, and in_stall falls again once that
// register has taken it. Operation code 3 is taken and dropped without a
// result.
// ----------------------------------------------------------------------------
module toroidal_life_like_automaton_step_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input item channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lla_pkg::OP_W-1:0]      in_operation,
  input  logic [lla_pkg::COLUMN_W-1:0]  in_column,
  input  logic [lla_pkg::ROW_W-1:0]     in_row,
  input  logic                          in_write_value,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lla_pkg::OP_W-1:0]      out_response_kind,
  output logic                          out_read_value,
  // Configuration write port
  input  logic                          cfg_wr_en,
  input  logic [lla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lla_pkg::MASK_W-1:0]    cfg_data
);
  import lla_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_CLEAR   = 9'b000000010,
    ST_CELL_RD = 9'b000000100,
    ST_CELL_RW = 9'b000001000,
    ST_LOAD    = 9'b000010000,
    ST_SWEEP   = 9'b000100000,
    ST_ROW_WR  = 9'b001000000,
    ST_ROW_LD  = 9'b010000000,
    ST_RESP    = 9'b100000000
  } state_t;

  // Control state
  state_t                state_r, state_nxt;
  logic                  bank_r, bank_nxt;
  logic [1:0]            lcnt_r, lcnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0]     survive_r, survive_nxt;
  logic [MASK_W-1:0]     birth_r, birth_nxt;
  logic [ROW_IDX_W-1:0]  row_r, row_nxt;
  logic [COL_IDX_W-1:0]  col_r, col_nxt;

  // Payload state
  op_t                   op_r, op_nxt;
  logic                  wval_r, wval_nxt;
  logic [ROW_IDX_W-1:0]  rd_row_r, rd_row_nxt;
  row_word_t             up_r, up_nxt;
  row_word_t             cur_r, cur_nxt;
  row_word_t             dn_r, dn_nxt;
  row_word_t             res_r, res_nxt;
  resp_t                 resp_kind_r, resp_kind_nxt;
  logic                  rval_r, rval_nxt;
  resp_t                 out_kind_r, out_kind_nxt;
  logic                  out_rval_r, out_rval_nxt;

  mem_req_t              mem_req;
  row_word_t             rd_data;
  row_word_t             mod_row;
  logic [7:0]            taps;
  logic                  new_cell;
  logic                  in_xfer;
  logic                  on_grid;

  lla_grid_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Window bit 0 is the current column, bit 1 the one to its right and the
  // top bit the one to its left, since the rows rotate right each cycle.
  assign taps = {dn_r[GRID_WIDTH-1], dn_r[0], dn_r[1],
                 cur_r[GRID_WIDTH-1], cur_r[1],
                 up_r[GRID_WIDTH-1], up_r[0], up_r[1]};

  lla_rule_unit u_rule (
    .taps         (taps),
    .center       (cur_r[0]),
    .survive_mask (survive_r),
    .birth_mask   (birth_r),
    .new_cell     (new_cell)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign on_grid  = (32'(in_column) < GRID_WIDTH) && (32'(in_row) < GRID_HEIGHT);

  always_comb begin
    state_nxt     = state_r;
    bank_nxt      = bank_r;
    lcnt_nxt      = lcnt_r;
    out_valid_nxt = out_valid_r;
    survive_nxt   = survive_r;
    birth_nxt     = birth_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    op_nxt        = op_r;
    wval_nxt      = wval_r;
    rd_row_nxt    = rd_row_r;
    up_nxt        = up_r;
    cur_nxt       = cur_r;
    dn_nxt        = dn_r;
    res_nxt       = res_r;
    resp_kind_nxt = resp_kind_r;
    rval_nxt      = rval_r;
    out_kind_nxt  = out_kind_r;
    out_rval_nxt  = out_rval_r;
    mem_req       = '0;
    mod_row       = rd_data;
    mod_row[col_r] = wval_r;

    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SURVIVE: survive_nxt = cfg_data;
        CFG_BIRTH:   birth_nxt   = cfg_data;
        default:     ;
      endcase
    end

    // The output register drops its item once the result side takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          op_nxt   = op_t'(in_operation);
          wval_nxt = in_write_value;
          col_nxt  = COL_IDX_W'(in_column);
          row_nxt  = ROW_IDX_W'(in_row);
          rval_nxt = 1'b0;
          case (op_t'(in_operation)) inside
            OP_WRITE, OP_READ: begin
              resp_kind_nxt = (op_t'(in_operation) == OP_WRITE) ? RESP_WRITE : RESP_READ;
              // A cell outside the grid skips the memory and answers at once.
              state_nxt = on_grid ? ST_CELL_RD : ST_RESP;
            end
            OP_STEP: begin
              resp_kind_nxt = RESP_STEP;
              row_nxt       = '0;
              col_nxt       = '0;
              rd_row_nxt    = ROW_IDX_W'(GRID_HEIGHT - 1);
              lcnt_nxt      = '0;
              state_nxt     = ST_LOAD;
            end
            default: ;
          endcase
        end
      end

      ST_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = mem_addr(bank_r, row_r);
        mem_req.wr_data = '0;
        row_nxt         = row_inc(row_r);
        if (row_r == ROW_IDX_W'(GRID_HEIGHT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_CELL_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = mem_addr(bank_r, row_r);
        state_nxt       = ST_CELL_RW;
      end

      ST_CELL_RW: begin
        if (op_r == OP_WRITE) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = mem_addr(bank_r, row_r);
          mem_req.wr_data = mod_row;
        end else begin
          rval_nxt = rd_data[col_r];
        end
        state_nxt = ST_RESP;
      end

      ST_LOAD: begin
        // Three reads fill the window with the last, first and second rows.
        if (lcnt_r != 2'd3) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = mem_addr(bank_r, rd_row_r);
          rd_row_nxt      = row_inc(rd_row_r);
        end
        if (lcnt_r != 2'd0) begin
          up_nxt  = cur_r;
          cur_nxt = dn_r;
          dn_nxt  = rd_data;
        end
        lcnt_nxt = lcnt_r + 2'd1;
        if (lcnt_r == 2'd3) begin
          state_nxt = ST_SWEEP;
        end
      end

      ST_SWEEP: begin
        res_nxt = {new_cell, res_r[GRID_WIDTH-1:1]};
        up_nxt  = {up_r[0], up_r[GRID_WIDTH-1:1]};
        cur_nxt = {cur_r[0], cur_r[GRID_WIDTH-1:1]};
        dn_nxt  = {dn_r[0], dn_r[GRID_WIDTH-1:1]};
        if (col_r == COL_IDX_W'(GRID_WIDTH - 1)) begin
          col_nxt   = '0;
          state_nxt = ST_ROW_WR;
        end else begin
          col_nxt = col_r + COL_IDX_W'(1);
        end
      end

      ST_ROW_WR: begin
        // New row goes to the idle bank; the row two below is fetched.
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = mem_addr(!bank_r, row_r);
        mem_req.wr_data = res_r;
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = mem_addr(bank_r, rd_row_r);
        rd_row_nxt      = row_inc(rd_row_r);
        state_nxt       = ST_ROW_LD;
      end

      ST_ROW_LD: begin
        up_nxt  = cur_r;
        cur_nxt = dn_r;
        dn_nxt  = rd_data;
        if (row_r == ROW_IDX_W'(GRID_HEIGHT - 1)) begin
          bank_nxt  = !bank_r;
          state_nxt = ST_RESP;
        end else begin
          row_nxt   = row_r + ROW_IDX_W'(1);
          state_nxt = ST_SWEEP;
        end
      end

      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = resp_kind_r;
          out_rval_nxt  = rval_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      bank_r      <= 1'b0;
      lcnt_r      <= '0;
      out_valid_r <= 1'b0;
      survive_r   <= SURVIVE_RESET;
      birth_r     <= BIRTH_RESET;
      row_r       <= '0;
      col_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      lcnt_r      <= lcnt_nxt;
      out_valid_r <= out_valid_nxt;
      survive_r   <= survive_nxt;
      birth_r     <= birth_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    wval_r      <= wval_nxt;
    rd_row_r    <= rd_row_nxt;
    up_r        <= up_nxt;
    cur_r       <= cur_nxt;
    dn_r        <= dn_nxt;
    res_r       <= res_nxt;
    resp_kind_r <= resp_kind_nxt;
    rval_r      <= rval_nxt;
    out_kind_r  <= out_kind_nxt;
    out_rval_r  <= out_rval_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_response_kind = out_kind_r;
  assign out_read_value    = out_rval_r;

`ifndef SYNTHESIS
  // Nothing is answered before the clearing pass has finished.
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !out_valid)
    else $error("result offered during the clearing pass");

  // The column sweep never leaves the grid.
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SWEEP |-> 32'(col_r) < GRID_WIDTH)
    else $error("column counter outside the grid");

  // The banks swap exactly when the last row of a step has been loaded.
  a_bank_swap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROW_LD && row_r == ROW_IDX_W'(GRID_HEIGHT - 1)) |=>
      (bank_r != $past(bank_r)) && (state_r == ST_RESP))
    else $error("bank did not swap at the end of a step");

  // Any meaningful command holds off the next transfer.
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_operation != OP_UNUSED) |=> in_stall)
    else $error("input taken again while a command is in flight");

  // A step always issues its result with a cleared read value.
  a_step_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_response_kind == RESP_STEP) |-> !out_read_value)
    else $error("step result carries a read value");
`endif

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for toroidal_life_like_automaton_step_core
// Drives cell writes, cell reads, unused codes and generation steps through
// the valid/stall channels with random idling on both sides. A behavioral
// copy of the torus and its rule masks predicts each response not hand-checked;
// a short table of mostly hand-checked probes runs first, then phases of
// random traffic around a small window, each under a different rule setting.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lla_pkg::*;

  localparam int RUN_LIMIT     = 3_000_000;
  localparam int PHASES        = 5;
  localparam int PRE_ITEMS     = 130;
  localparam int POST_ITEMS    = 130;
  localparam int WINDOW        = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int PRESSURE_AT   = 300;
  localparam int PRESSURE_HOLD = 500;

  typedef struct packed {
    resp_t kind;
    logic  value;
  } cell_response_t;

  // One row of the opening table. Rows with hand_checked set carry their
  // own expectation (has_response tells whether any response follows).
  typedef struct packed {
    op_t                 op;
    logic [COLUMN_W-1:0] col;
    logic [ROW_W-1:0]    row;
    logic                wv;
    bit                  hand_checked;
    bit                  has_response;
    resp_t               kind;
    logic                value;
  } probe_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_operation = OP_WRITE;
  logic [COLUMN_W-1:0]  in_column = '0;
  logic [ROW_W-1:0]     in_row = '0;
  logic                 in_write_value = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [OP_W-1:0]      out_response_kind;
  logic                 out_read_value;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SURVIVE;
  logic [MASK_W-1:0]    cfg_data = '0;

  // Behavioral copy of the torus and of the rule registers.
  bit [GRID_WIDTH-1:0] live_rows [GRID_HEIGHT];
  logic [MASK_W-1:0]   survive_rule = SURVIVE_RESET;
  logic [MASK_W-1:0]   birth_rule = BIRTH_RESET;

  cell_response_t awaited_responses [$];
  int             mismatch_count = 0;
  int             responses_taken = 0;
  int             cycle_count = 0;
  int             calm_left [2] = '{0, 0};
  int             window_col0, window_row0;

  probe_t opening_probes [24] = '{
    '{OP_READ,   9'd0,   8'd0,   1'b0, 1'b1, 1'b1, RESP_READ,  1'b0},
    '{OP_READ,   9'd319, 8'd239, 1'b0, 1'b1, 1'b1, RESP_READ,  1'b0},
    '{OP_WRITE,  9'd0,   8'd0,   1'b1, 1'b1, 1'b1, RESP_WRITE, 1'b0},
    '{OP_READ,   9'd0,   8'd0,   1'b0, 1'b1, 1'b1, RESP_READ,  1'b1},
    '{OP_WRITE,  9'd319, 8'd239, 1'b1, 1'b1, 1'b1, RESP_WRITE, 1'b0},
    '{OP_READ,   9'd319, 8'd239, 1'b0, 1'b1, 1'b1, RESP_READ,  1'b1},
    '{OP_WRITE,  9'd320, 8'd0,   1'b1, 1'b1, 1'b1, RESP_WRITE, 1'b0},
    '{OP_READ,   9'd320, 8'd0,   1'b0, 1'b1, 1'b1, RESP_READ,  1'b0},
    '{OP_WRITE,  9'd0,   8'd240, 1'b1, 1'b1, 1'b1, RESP_WRITE, 1'b0},
    '{OP_READ,   9'd0,   8'd240, 1'b0, 1'b1, 1'b1, RESP_READ,  1'b0},
    '{OP_WRITE,  9'd511, 8'd255, 1'b1, 1'b1, 1'b1, RESP_WRITE, 1'b0},
    '{OP_READ,   9'd511, 8'd255, 1'b0, 1'b1, 1'b1, RESP_READ,  1'b0},
    '{OP_UNUSED, 9'd511, 8'd255, 1'b1, 1'b1, 1'b0, RESP_WRITE, 1'b0},
    '{OP_WRITE,  9'd319, 8'd0,   1'b1, 1'b0, 1'b0, RESP_WRITE, 1'b0},
    '{OP_WRITE,  9'd0,   8'd239, 1'b1, 1'b0, 1'b0, RESP_WRITE, 1'b0},
    '{OP_WRITE,  9'd1,   8'd1,   1'b0, 1'b1, 1'b1, RESP_WRITE, 1'b0},
    '{OP_STEP,   9'd0,   8'd0,   1'b0, 1'b1, 1'b1, RESP_STEP,  1'b0},
    '{OP_READ,   9'd0,   8'd0,   1'b0, 1'b0, 1'b0, RESP_WRITE, 1'b0},
    '{OP_READ,   9'd1,   8'd1,   1'b0, 1'b0, 1'b0, RESP_WRITE, 1'b0},
    '{OP_READ,   9'd5,   8'd5,   1'b0, 1'b0, 1'b0, RESP_WRITE, 1'b0},
    '{OP_READ,   9'd318, 8'd238, 1'b0, 1'b0, 1'b0, RESP_WRITE, 1'b0},
    '{OP_WRITE,  9'd160, 8'd120, 1'b0, 1'b1, 1'b1, RESP_WRITE, 1'b0},
    '{OP_READ,   9'd160, 8'd120, 1'b0, 1'b1, 1'b1, RESP_READ,  1'b0},
    '{OP_READ,   9'd319, 8'd0,   1'b0, 1'b0, 1'b0, RESP_WRITE, 1'b0}
  };

  toroidal_life_like_automaton_step_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_column         (in_column),
    .in_row            (in_row),
    .in_write_value    (in_write_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_response_kind (out_response_kind),
    .out_read_value    (out_read_value),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #1 clk = ~clk;

  // Idle cycles before the next transfer on one side (0 sender, 1 receiver).
  // Now and then a side goes calm for a run of back-to-back transfers.
  function automatic int idle_cycles(input int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      calm_left[side] = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // One generation on the torus: every cell is judged from the old grid.
  function automatic void advance_grid();
    bit [GRID_WIDTH-1:0] fresh [GRID_HEIGHT];
    int n;
    for (int r = 0; r < GRID_HEIGHT; r++) begin
      for (int c = 0; c < GRID_WIDTH; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0)
              n += live_rows[(r + dr + GRID_HEIGHT) % GRID_HEIGHT]
                            [(c + dc + GRID_WIDTH) % GRID_WIDTH];
          end
        end
        fresh[r][c] = live_rows[r][c] ? survive_rule[n] : birth_rule[n];
      end
    end
    live_rows = fresh;
  endfunction

  // Applies one accepted item to the grid copy; returns whether it answers.
  function automatic bit predict_cell_op(input op_t op, input logic [COLUMN_W-1:0] col,
                                         input logic [ROW_W-1:0] row, input logic wv,
                                         output cell_response_t resp);
    bit on_grid;
    on_grid = (col < GRID_WIDTH) && (row < GRID_HEIGHT);
    resp.kind = RESP_WRITE;
    resp.value = 1'b0;
    case (op)
      OP_WRITE: begin
        if (on_grid) live_rows[row][col] = wv;
        return 1'b1;
      end
      OP_READ: begin
        resp.kind = RESP_READ;
        resp.value = on_grid ? live_rows[row][col] : 1'b0;
        return 1'b1;
      end
      OP_STEP: begin
        advance_grid();
        resp.kind = RESP_STEP;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Offers one item and returns at the edge where it transfers. The
  // expectation is queued right there, before any response can come back.
  task automatic offer_item(input op_t op, input logic [COLUMN_W-1:0] col,
                            input logic [ROW_W-1:0] row, input logic wv,
                            input bit hand_checked = 1'b0, input bit has_response = 1'b0,
                            input resp_t t_kind = RESP_WRITE, input logic t_value = 1'b0);
    cell_response_t predicted;
    bit answers;
    int gap;
    gap = idle_cycles(0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_column      <= col;
    in_row         <= row;
    in_write_value <= wv;
    do @(posedge clk); while (in_stall !== 1'b0);
    answers = predict_cell_op(op, col, row, wv, predicted);
    if (hand_checked) begin
      if (has_response) awaited_responses.push_back(cell_response_t'{t_kind, t_value});
    end else if (answers) begin
      awaited_responses.push_back(predicted);
    end
  endtask

  // Noise: unused codes, off-grid and random cells, fields over their full range.
  task automatic stray_item();
    case ($urandom_range(0, 3))
      0: offer_item(OP_UNUSED, COLUMN_W'($urandom_range(0, 511)),
                    ROW_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      1: offer_item(OP_WRITE, COLUMN_W'($urandom_range(GRID_WIDTH, 511)),
                    ROW_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      2: offer_item(OP_READ, COLUMN_W'($urandom_range(0, 511)),
                    ROW_W'($urandom_range(GRID_HEIGHT, 255)), 1'($urandom_range(0, 1)));
      default: offer_item(op_t'($urandom_range(0, 1)), COLUMN_W'($urandom_range(0, 511)),
                          ROW_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endcase
  endtask

  // A cell in the current window, widened by margin on every side (wraps).
  function automatic logic [COLUMN_W-1:0] window_col(input int margin);
    return COLUMN_W'((window_col0 + GRID_WIDTH - margin
                      + int'($urandom_range(0, WINDOW - 1 + 2 * margin))) % GRID_WIDTH);
  endfunction

  function automatic logic [ROW_W-1:0] window_row(input int margin);
    return ROW_W'((window_row0 + GRID_HEIGHT - margin
                   + int'($urandom_range(0, WINDOW - 1 + 2 * margin))) % GRID_HEIGHT);
  endfunction

  // Drops valid, waits until every response is back, and then lets the core settle.
  task automatic drain_responses();
    in_valid <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_rules(input logic [MASK_W-1:0] survive, input logic [MASK_W-1:0] birth);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_SURVIVE;
    cfg_data  <= survive;
    @(posedge clk);
    cfg_index <= CFG_BIRTH;
    cfg_data  <= birth;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    survive_rule = survive;
    birth_rule = birth;
  endtask

  initial begin : stimulus
    logic [MASK_W-1:0] survive, birth;
    int pick;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_probes[i])
      offer_item(opening_probes[i].op, opening_probes[i].col, opening_probes[i].row,
                 opening_probes[i].wv, opening_probes[i].hand_checked,
                 opening_probes[i].has_response, opening_probes[i].kind,
                 opening_probes[i].value);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_responses();
      case (phase)
        0: begin survive = 9'd12;  birth = 9'd8;   end
        1: begin survive = 9'd0;   birth = 9'd511; end
        2: begin survive = 9'd511; birth = 9'd0;   end
        default: begin
          survive = MASK_W'($urandom_range(0, 511));
          birth   = MASK_W'($urandom_range(0, 511));
        end
      endcase
      load_rules(survive, birth);

      // The first window sits on the corner so that its pattern wraps.
      if (phase == 0) begin
        window_col0 = GRID_WIDTH - 4;
        window_row0 = GRID_HEIGHT - 4;
      end else begin
        window_col0 = $urandom_range(0, GRID_WIDTH - 1);
        window_row0 = $urandom_range(0, GRID_HEIGHT - 1);
      end

      // Seed a pattern in the window, mixed with reads and noise.
      repeat (PRE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 6)
          offer_item(OP_WRITE, window_col(0), window_row(0), $urandom_range(0, 9) < 4);
        else if (pick < 8)
          offer_item(OP_READ, window_col(0), window_row(0), 1'($urandom_range(0, 1)));
        else if (pick == 8)
          stray_item();
        else
          offer_item(OP_READ, COLUMN_W'($urandom_range(0, GRID_WIDTH - 1)),
                     ROW_W'($urandom_range(0, GRID_HEIGHT - 1)), 1'b0);
      end

      offer_item(OP_STEP, COLUMN_W'($urandom_range(0, 511)), ROW_W'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));

      // Read back around the window, including the ring of cells just outside it.
      repeat (POST_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 7)
          offer_item(OP_READ, window_col(1), window_row(1), 1'($urandom_range(0, 1)));
        else if (pick == 7)
          offer_item(OP_WRITE, window_col(1), window_row(1), 1'($urandom_range(0, 1)));
        else if (pick == 8)
          stray_item();
        else
          offer_item(OP_READ, COLUMN_W'($urandom_range(0, GRID_WIDTH - 1)),
                     ROW_W'($urandom_range(0, GRID_HEIGHT - 1)), 1'b0);
      end
    end

    drain_responses();
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Response side: random stalls, one long hold-off that backs the core up,
  // and a field-by-field check against the oldest awaited response.
  initial begin : response_sink
    cell_response_t want;
    int hold;
    @(posedge clk);
    forever begin
      hold = (responses_taken == PRESSURE_AT) ? PRESSURE_HOLD : idle_cycles(1);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      responses_taken++;
      if (awaited_responses.size() == 0) begin
        $display("%0t: response with none awaited, expected nothing, got kind %0d value %0d",
                 $time, out_response_kind, out_read_value);
        mismatch_count++;
      end else begin
        want = awaited_responses.pop_front();
        if (out_response_kind !== want.kind) begin
          $display("%0t: response kind mismatch, expected %0d, got %0d",
                   $time, want.kind, out_response_kind);
          mismatch_count++;
        end
        if (out_read_value !== want.value) begin
          $display("%0t: read value mismatch, expected %0d, got %0d",
                   $time, want.value, out_read_value);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
